// ===== rtl/dff_pkg.sv =====
`timescale 1ns / 1ps

package dff_pkg;

  // Widest delimiter held in configuration, in bytes.
  localparam int PATTERN_BYTES = 8;
  // Bytes searched per buffer; later bytes only set the overflow flag.
  localparam int MAX_STREAM    = 65535;

  localparam int POS_W   = $clog2(MAX_STREAM + 1);
  localparam int IDX_W   = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int LEN_W   = 4;
  localparam int PAT_W   = 64;
  localparam int FIELD_W = 16;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FRONT_PATTERN = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRONT_LENGTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BACK_PATTERN  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_BACK_LENGTH   = 2'd3;

  typedef enum logic [1:0] {
    PH_FRONT,
    PH_BACK,
    PH_DONE
  } phase_t;

  // Newest byte at index 0.
  typedef logic [PATTERN_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] field_offset;
    logic [FIELD_W-1:0] field_length;
    logic               too_long;
  } result_t;

  // Length register to the number of bytes compared: zero counts as one,
  // anything above the window depth is clipped to it.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] l;
    l = raw;
    if (l == '0) begin
      l = LEN_W'(1);
    end
    if (l > LEN_W'(PATTERN_BYTES)) begin
      l = LEN_W'(PATTERN_BYTES);
    end
    return l;
  endfunction

endpackage

// ===== rtl/dff_match.sv =====
`timescale 1ns / 1ps

// Compares the newest len window bytes with the first len pattern bytes.
// Pattern byte 0 lines up with the oldest of those window bytes.
module dff_match (
  input  dff_pkg::window_t                win,
  input  logic [dff_pkg::PAT_W-1:0]       pattern,
  input  logic [dff_pkg::LEN_W-1:0]       len,
  output logic                            hit
);
  import dff_pkg::*;

  always_comb begin
    logic [LEN_W-1:0] pos;
    hit = 1'b1;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      pos = len - LEN_W'(1) - LEN_W'(k);
      if ((LEN_W'(k) < len) && (win[pos[IDX_W-1:0]] != pattern[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/delimited_field_finder_unit.sv =====
`timescale 1ns / 1ps

// Delimited field finder.
// Input channel (in_valid / in_stall): one buffer byte per transfer, is_final
// on the last byte of the buffer. The search runs as bytes arrive: first the
// front delimiter, then the first back delimiter lying wholly after it.
// Output channel (out_valid / out_stall): one result per buffer, produced by
// the transfer of the final byte: found, field offset and length, too_long.
// Result path: registered into the output register, or the skid entry while stalled.
// Throughput: one byte per cycle unless in_stall; the window compare for both
// delimiters is a single level of byte comparators behind the window register.
// Stall: results go to an output register backed by one skid entry, so input
// keeps flowing while a result waits; in_stall rises only when both hold a
// result, and falls once the receiver takes one.
// Config port: cfg_write / cfg_index / cfg_data, written between buffers.
// Reset: synchronous, clears the search state, empties the output side, and
// sets both delimiters to a single zero byte.
module delimited_field_finder_unit (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          cfg_write,
  input  logic [dff_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [dff_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          is_final,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [dff_pkg::FIELD_W-1:0]   field_offset,
  output logic [dff_pkg::FIELD_W-1:0]   field_length,
  output logic                          too_long
);
  import dff_pkg::*;

  // configuration registers
  logic [PAT_W-1:0] front_pattern;
  logic [LEN_W-1:0] front_length;
  logic [PAT_W-1:0] back_pattern;
  logic [LEN_W-1:0] back_length;

  // per-buffer search state
  window_t          window;
  logic [POS_W-1:0] position;
  phase_t           phase;
  logic [POS_W-1:0] field_start;
  logic [POS_W-1:0] field_size;
  logic             overflow_seen;

  window_t          window_next;
  logic [POS_W-1:0] position_next;
  phase_t           phase_next;
  logic [POS_W-1:0] field_start_next;
  logic [POS_W-1:0] field_size_next;
  logic             overflow_next;

  logic             accept;
  logic             beyond;        // this byte is past the position limit
  logic [LEN_W-1:0] flen;
  logic [LEN_W-1:0] blen;
  logic             front_hit;
  logic             back_hit;
  logic             front_ok;
  logic             back_ok;

  // output register plus skid entry
  result_t          res;
  logic             res_valid;
  result_t          out_res;
  result_t          skid_res;
  logic             skid_valid;
  logic             out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid;
  assign out_free  = !out_valid || !out_stall;
  assign res_valid = accept && is_final;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      front_pattern <= '0;
      front_length  <= LEN_W'(1);
      back_pattern  <= '0;
      back_length   <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRONT_PATTERN: front_pattern <= cfg_data[PAT_W-1:0];
        REG_FRONT_LENGTH:  front_length  <= cfg_data[LEN_W-1:0];
        REG_BACK_PATTERN:  back_pattern  <= cfg_data[PAT_W-1:0];
        REG_BACK_LENGTH:   back_length   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign flen = eff_len(front_length);
  assign blen = eff_len(back_length);

  // ---------------------------------------------------------------- window
  assign beyond = position >= POS_W'(MAX_STREAM);

  always_comb begin
    window_next = window;
    position_next = position;
    if (!beyond) begin
      window_next[0] = data_byte;
      for (int j = 1; j < PATTERN_BYTES; j++) begin
        window_next[j] = window[j-1];
      end
      position_next = position + POS_W'(1);
    end
  end

  // compare against the window as it stands after this byte
  dff_match u_front_match (
    .win     (window_next),
    .pattern (front_pattern),
    .len     (flen),
    .hit     (front_hit)
  );

  dff_match u_back_match (
    .win     (window_next),
    .pattern (back_pattern),
    .len     (back_length == '0 ? blen : blen),
    .hit     (back_hit)
  );

  // a match counts only once enough bytes are in: front since the buffer began, back since the front match
  assign front_ok = !beyond && (position_next >= POS_W'(flen)) && front_hit;
  assign back_ok  = !beyond && ((position_next - field_start) >= POS_W'(blen)) && back_hit;

  // ---------------------------------------------------------------- phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_FRONT: if (front_ok) phase_next = PH_BACK;
      PH_BACK:  if (back_ok)  phase_next = PH_DONE;
      PH_DONE:  phase_next = PH_DONE;
      default:  phase_next = PH_FRONT;
    endcase
  end

  // field bounds and the result for a final byte
  always_comb begin
    field_start_next = field_start;
    field_size_next  = field_size;
    if (phase == PH_FRONT && front_ok) begin
      field_start_next = position_next;
    end
    if (phase == PH_BACK && back_ok) begin
      field_size_next = position_next - POS_W'(blen) - field_start;
    end
    overflow_next = overflow_seen || beyond;

    res.too_long     = overflow_next;
    res.found        = !overflow_next && (phase_next == PH_DONE);
    res.field_offset = res.found ? FIELD_W'(field_start_next) : '0;
    res.field_length = res.found ? FIELD_W'(field_size_next) : '0;
  end

  // the last byte of a buffer returns the search state to its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      position      <= '0;
      phase         <= PH_FRONT;
      field_start   <= '0;
      field_size    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (is_final) begin
        window        <= '0;
        position      <= '0;
        phase         <= PH_FRONT;
        field_start   <= '0;
        field_size    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        window        <= window_next;
        position      <= position_next;
        phase         <= phase_next;
        field_start   <= field_start_next;
        field_size    <= field_size_next;
        overflow_seen <= overflow_next;
      end
    end
  end

  // ---------------------------------------------------------------- output
  // skid entry fills only when a result arrives while the output is stalled;
  // it is empty whenever a transfer is taken, so nothing is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && res_valid) begin
      skid_res <= res;
    end
  end

  assign found        = out_res.found;
  assign field_offset = out_res.field_offset;
  assign field_length = out_res.field_length;
  assign too_long     = out_res.too_long;

  // ---------------------------------------------------------------- checks
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_overflow_at_limit: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (position == POS_W'(MAX_STREAM)))
    else $error("overflow flagged below the position limit");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && is_final) |=> (position == '0 && phase == PH_FRONT
                                              && !overflow_seen))
    else $error("search state not cleared after final byte");

  a_field_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |->
      ({1'b0, field_start} + {1'b0, field_size} <= {1'b0, position}))
    else $error("field extends past the bytes seen");

endmodule

// ===== verif/delimited_field_finder_unit_tb.sv =====
`timescale 1ns / 1ps

// Bench for delimited_field_finder_unit.
// Byte transfers on the input channel feed a local scan of each buffer; every
// final byte queues one expected result, which is compared with the next result
// transfer. Directed buffers come first, then two buffers at the position
// limit, then random phases that mostly carry well-formed delimited fields.
module delimited_field_finder_unit_tb;
  import dff_pkg::*;

  // Cycles with no transfer of any kind before the run is abandoned. Gaps are
  // short random runs and the result is registered behind the final byte,
  // so a correct run never gets near this.
  localparam int HANG_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = REG_FRONT_PATTERN;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = 8'h00;
  logic                is_final = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                found;
  logic [FIELD_W-1:0]  field_offset;
  logic [FIELD_W-1:0]  field_length;
  logic                too_long;

  // Hand-written expectation that travels with the final byte of a row.
  logic                row_typed = 1'b0;
  result_t             row_want = '0;

  // No idling on either side while set.
  logic                quiet = 1'b0;

  delimited_field_finder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .is_final     (is_final),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .field_offset (field_offset),
    .field_length (field_length),
    .too_long     (too_long)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Field scan: register copies and per-buffer search state
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0]  front_pat = '0;
  logic [LEN_W-1:0]  front_len_reg = 4'd1;
  logic [PAT_W-1:0]  back_pat = '0;
  logic [LEN_W-1:0]  back_len_reg = 4'd1;

  window_t           win = '0;
  int                scan_pos = 0;
  phase_t            stage = PH_FRONT;
  int                field_begin = 0;
  int                field_bytes = 0;
  bit                overrun = 1'b0;

  result_t           pending_fields[$];
  int                bad_results = 0;
  int                hang_cycles = 0;

  // Bytes actually compared for a length register: 0 acts as 1, clip at 8.
  function automatic int span(input logic [LEN_W-1:0] r);
    int n;
    n = int'(r);
    if (n == 0) n = 1;
    if (n > PATTERN_BYTES) n = PATTERN_BYTES;
    return n;
  endfunction

  // Newest n window bytes against the first n pattern bytes.
  function automatic bit tail_equals(input logic [PAT_W-1:0] pat, input int n);
    for (int k = 0; k < n; k++) begin
      if (win[n-1-k] != pat[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t outcome(input bit f, input int off, input int len,
                                      input bit tl);
    result_t r;
    r.found        = f;
    r.field_offset = FIELD_W'(off);
    r.field_length = FIELD_W'(len);
    r.too_long     = tl;
    return r;
  endfunction

  task automatic scan_byte(input logic [7:0] b, input bit fin, output result_t r);
    int fl;
    int bl;
    r = '0;
    if (scan_pos >= MAX_STREAM) begin
      overrun = 1'b1;   // past the limit: flagged, never searched
    end else begin
      fl = span(front_len_reg);
      bl = span(back_len_reg);
      win = {win[PATTERN_BYTES-2:0], b};
      scan_pos++;
      if (stage == PH_FRONT) begin
        if (scan_pos >= fl && tail_equals(front_pat, fl)) begin
          field_begin = scan_pos;
          stage = PH_BACK;
        end
      end else if (stage == PH_BACK) begin
        // back delimiter must not reach into the front match
        if (scan_pos - field_begin >= bl && tail_equals(back_pat, bl)) begin
          field_bytes = scan_pos - bl - field_begin;
          stage = PH_DONE;
        end
      end
    end
    if (fin) begin
      if (overrun) begin
        r.too_long = 1'b1;
      end else if (stage == PH_DONE) begin
        r.found        = 1'b1;
        r.field_offset = FIELD_W'(field_begin);
        r.field_length = FIELD_W'(field_bytes);
      end
      win = '0;
      scan_pos = 0;
      stage = PH_FRONT;
      field_begin = 0;
      field_bytes = 0;
      overrun = 1'b0;
    end
  endtask

  function automatic void flag_error(input string what, input result_t want,
                                     input result_t got);
    bad_results++;
    if (bad_results <= 10) begin
      $display({"%0t: %s: expected found=%0b off=%0d len=%0d too_long=%0b, ",
                "got found=%0b off=%0d len=%0d too_long=%0b"},
               $time, what, want.found, want.field_offset, want.field_length,
               want.too_long, got.found, got.field_offset, got.field_length,
               got.too_long);
    end
  endfunction

  // Register writes and byte transfers, sampled before this edge's updates.
  always @(posedge clk) begin
    result_t r;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRONT_PATTERN: front_pat = cfg_data;
          REG_FRONT_LENGTH:  front_len_reg = cfg_data[LEN_W-1:0];
          REG_BACK_PATTERN:  back_pat = cfg_data;
          REG_BACK_LENGTH:   back_len_reg = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        scan_byte(data_byte, is_final, r);
        if (is_final) pending_fields.push_back(row_typed ? row_want : r);
      end
    end
  end

  // Result transfers against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = outcome(found, field_offset, field_length, too_long);
      if (pending_fields.size() == 0) begin
        flag_error("result with none pending", '0, got);
      end else begin
        want = pending_fields.pop_front();
        if (got.found !== want.found || got.field_offset !== want.field_offset ||
            got.field_length !== want.field_length ||
            got.too_long !== want.too_long) begin
          flag_error("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    if (cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
    if (hang_cycles >= HANG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Settings the generators build buffers from.
  logic [PAT_W-1:0]  gen_front_pat = '0;
  logic [LEN_W-1:0]  gen_front_len = 4'd1;
  logic [PAT_W-1:0]  gen_back_pat = '0;
  logic [LEN_W-1:0]  gen_back_len = 4'd1;

  typedef struct {
    bit                set_cfg;
    logic [PAT_W-1:0]  fp;
    logic [LEN_W-1:0]  fl;
    logic [PAT_W-1:0]  bp;
    logic [LEN_W-1:0]  bl;
    int                nbytes;
    logic [71:0]       text;    // first byte in the lowest byte
    bit                typed;
    result_t           want;
  } dir_row_t;

  dir_row_t dir_rows[7];

  // One byte transfer, with a random gap in front of it.
  task automatic send_byte(input logic [7:0] b, input bit fin, input bit typed,
                           input result_t want);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_final  <= fin;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every result is in.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [PAT_W-1:0] fp, input logic [LEN_W-1:0] fl,
                           input logic [PAT_W-1:0] bp, input logic [LEN_W-1:0] bl);
    settle();
    gen_front_pat = fp;
    gen_front_len = fl;
    gen_back_pat  = bp;
    gen_back_len  = bl;
    cfg_write <= 1'b1;
    cfg_index <= REG_FRONT_PATTERN;
    cfg_data  <= fp;
    @(posedge clk);
    // upper bits of a length write are junk and must be dropped
    cfg_index <= REG_FRONT_LENGTH;
    cfg_data  <= {$urandom, 28'($urandom), fl};
    @(posedge clk);
    cfg_index <= REG_BACK_PATTERN;
    cfg_data  <= bp;
    @(posedge clk);
    cfg_index <= REG_BACK_LENGTH;
    cfg_data  <= {$urandom, 28'($urandom), bl};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random delimiter: free bytes, a two-letter alphabet, or one repeated byte.
  function automatic logic [PAT_W-1:0] pick_pattern();
    logic [PAT_W-1:0] p;
    logic [7:0] a;
    logic [7:0] z;
    a = 8'($urandom_range(255));
    z = 8'($urandom_range(255));
    case ($urandom_range(2))
      0: p = {$urandom, $urandom};
      1: for (int k = 0; k < PATTERN_BYTES; k++) p[8*k +: 8] = $urandom_range(1) ? a : z;
      default: p = {PATTERN_BYTES{a}};
    endcase
    return p;
  endfunction

  // Noise that often borrows delimiter bytes, so partial matches show up.
  function automatic logic [7:0] filler();
    case ($urandom_range(3))
      2: return gen_front_pat[8*$urandom_range(span(gen_front_len) - 1) +: 8];
      3: return gen_back_pat[8*$urandom_range(span(gen_back_len) - 1) +: 8];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Buffer of total bytes with front delimiter at mark, a 5-byte field and
  // the back delimiter right after it.
  task automatic long_run(input int total, input int mark, input bit typed,
                          input result_t want);
    logic [7:0] b;
    for (int i = 0; i < total; i++) begin
      if (i >= mark && i < mark + 8) begin
        b = gen_front_pat[8*(i-mark) +: 8];
      end else if (i >= mark + 13 && i < mark + 21) begin
        b = gen_back_pat[8*(i-mark-13) +: 8];
      end else begin
        b = 8'($urandom_range(255));
      end
      send_byte(b, i == total - 1, typed && i == total - 1, want);
    end
  endtask

  initial begin
    logic [7:0] buf_q[$];
    logic [LEN_W-1:0] fl;
    logic [LEN_W-1:0] bl;
    logic [PAT_W-1:0] fp;
    logic [PAT_W-1:0] bp;
    int sent;
    int kind;

    // Default delimiters are a single zero byte each.
    dir_rows[0] = '{1'b0, '0, 4'd0, '0, 4'd0, 2, 72'h00_00,
                    1'b1, outcome(1, 1, 0, 0)};
    dir_rows[1] = '{1'b0, '0, 4'd0, '0, 4'd0, 1, 72'hFF,
                    1'b1, outcome(0, 0, 0, 0)};
    // "<A>" and a back mark ahead of the front one
    dir_rows[2] = '{1'b1, 64'h3C, 4'd1, 64'h3E, 4'd1, 3, 72'h3E_41_3C,
                    1'b1, outcome(1, 1, 1, 0)};
    dir_rows[3] = '{1'b0, '0, 4'd0, '0, 4'd0, 3, 72'h3E_3C_3E,
                    1'b1, outcome(1, 2, 0, 0)};
    // front length 0 acts as 1; back length 15 acts as 8, zero bytes inside
    dir_rows[4] = '{1'b1, 64'hFFFF_FFFF_FFFF_FF80, 4'd0,
                    64'h0706_0504_0302_0100, 4'd15, 9, 72'h07_06_05_04_03_02_01_00_80,
                    1'b1, outcome(1, 1, 0, 0)};
    // back delimiter overlapping the front match does not count
    dir_rows[5] = '{1'b1, 64'h4241, 4'd2, 64'h4342, 4'd2, 3, 72'h43_42_41,
                    1'b1, outcome(0, 0, 0, 0)};
    dir_rows[6] = '{1'b0, '0, 4'd0, '0, 4'd0, 4, 72'h43_42_42_41,
                    1'b0, '0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_cfg) begin
        configure(dir_rows[r].fp, dir_rows[r].fl, dir_rows[r].bp, dir_rows[r].bl);
      end
      for (int i = 0; i < dir_rows[r].nbytes; i++) begin
        send_byte(dir_rows[r].text[8*i +: 8], i == dir_rows[r].nbytes - 1,
                  dir_rows[r].typed && i == dir_rows[r].nbytes - 1, dir_rows[r].want);
      end
    end

    // Exactly at the limit, field near the top of the offset range; then
    // four past it with both delimiters early, which must still read too long.
    configure({$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'd8);
    long_run(MAX_STREAM, MAX_STREAM - 40, 1'b0, '0);
    long_run(MAX_STREAM + 4, 3, 1'b1, outcome(0, 0, 0, 1));

    for (int ph = 0; ph < 12; ph++) begin
      fl = 4'($urandom_range(15));
      bl = 4'($urandom_range(15));
      fp = pick_pattern();
      bp = pick_pattern();
      case (ph)
        0: begin fl = 4'd8; bl = 4'd8; end
        1: begin fl = 4'd1; bl = 4'd1; end
        2: begin fl = 4'd0; bl = 4'd15; end
        3: begin fp = '1; bp = '0; end
        default: ;
      endcase
      configure(fp, fl, bp, bl);
      quiet <= (ph == 5);
      sent = 0;
      while (sent < 160) begin
        buf_q.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
          repeat ($urandom_range(4)) buf_q.push_back(filler());
          for (int k = 0; k < span(gen_front_len); k++) buf_q.push_back(gen_front_pat[8*k +: 8]);
          repeat ($urandom_range(6)) buf_q.push_back(filler());
          for (int k = 0; k < span(gen_back_len); k++) buf_q.push_back(gen_back_pat[8*k +: 8]);
          repeat ($urandom_range(2)) buf_q.push_back(filler());
        end else if (kind < 85) begin
          repeat ($urandom_range(3)) buf_q.push_back(filler());
          for (int k = 0; k < span(gen_front_len); k++) buf_q.push_back(gen_front_pat[8*k +: 8]);
          repeat ($urandom_range(5)) buf_q.push_back(filler());
        end else begin
          repeat ($urandom_range(1, 12)) buf_q.push_back(filler());
        end
        if (buf_q.size() == 0) buf_q.push_back(filler());
        foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, '0);
        sent += buf_q.size();
        // now and then let the result side run dry before going on
        if ($urandom_range(19) == 0) settle();
      end
    end
    quiet <= 1'b0;

    settle();
    repeat (16) @(posedge clk);
    if (bad_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dff_pkg.sv
rtl/dff_match.sv
rtl/delimited_field_finder_unit.sv
verif/delimited_field_finder_unit_tb.sv
